// File: hw/rtl/dpw_pkg.sv
// ----------------------------------------------------------------------------
// dpw_pkg: shared types and constants
// Register indexes, depth window, image bounds and output range for the
// depth pixel to world point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CAMERA_CENTER = 3'd0,
    CFG_INV_FOCAL     = 3'd1,
    CFG_POSE_ROW_X    = 3'd2,
    CFG_POSE_ROW_Y    = 3'd3,
    CFG_POSE_ROW_Z    = 3'd4
  } cfg_idx_t;

  // Depth window in Q4.12 metres: keep 41 .. 40960 (0.01 m .. 10 m)
  localparam logic [15:0] DEPTH_MIN_RAW = 16'd41;
  localparam logic [15:0] DEPTH_MAX_RAW = 16'd40960;

  // Image bounds
  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned MAX_ROWS    = 4096;

  // Saturation bounds of a Q11.12 world coordinate
  localparam logic signed [47:0] OUT_MAX = 48'sd8388607;
  localparam logic signed [47:0] OUT_MIN = -48'sd8388608;

  // Reset values of the pose: identity rotation, zero translation
  localparam logic [63:0] POSE_X_RST = 64'd16384;
  localparam logic [63:0] POSE_Y_RST = 64'd1073741824;
  localparam logic [63:0] POSE_Z_RST = 64'd70368744177664;

  // Colour bytes that ride along with a pixel
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  // Load enables of the three world-transform stages
  typedef struct packed {
    logic mul_ld;
    logic sum_ld;
    logic sat_ld;
  } row_en_t;

endpackage

// File: hw/rtl/dpw_world_row.sv
// ----------------------------------------------------------------------------
// dpw_world_row: one row of the pose transform
// Three registered stages: coefficient products, sum with translation and
// rounding bias, then floor shift and saturation to Q11.12.
// ----------------------------------------------------------------------------
module dpw_world_row (
  input  logic                clk,
  input  dpw_pkg::row_en_t    en,
  input  logic [63:0]         pose_row,
  input  logic signed [28:0]  cam_x,
  input  logic signed [28:0]  cam_y,
  input  logic [15:0]         cam_z,
  output logic signed [23:0]  world
);

  logic signed [44:0] px_r;
  logic signed [44:0] py_r;
  logic signed [32:0] pz_r;
  logic signed [15:0] tr_r;
  logic signed [47:0] acc_r;
  logic signed [47:0] acc_nxt;
  logic signed [47:0] shf;
  logic signed [23:0] world_r;
  logic signed [23:0] world_nxt;

  // products in Q.26
  always_ff @(posedge clk) begin
    if (en.mul_ld) begin
      px_r <= $signed(pose_row[15:0])  * cam_x;
      py_r <= $signed(pose_row[31:16]) * cam_y;
      pz_r <= $signed(pose_row[47:32]) * $signed({1'b0, cam_z});
      tr_r <= $signed(pose_row[63:48]);
    end
  end

  // translation moves from Q.12 to Q.26; add one half for rounding
  assign acc_nxt = 48'(px_r) + 48'(py_r) + 48'(pz_r) + (48'(tr_r) <<< 14)
                 + 48'sd8192;

  always_ff @(posedge clk) begin
    if (en.sum_ld) begin
      acc_r <= acc_nxt;
    end
  end

  assign shf = acc_r >>> 14;

  always_comb begin
    priority if (shf > dpw_pkg::OUT_MAX) begin
      world_nxt = dpw_pkg::OUT_MAX[23:0];
    end else if (shf < dpw_pkg::OUT_MIN) begin
      world_nxt = dpw_pkg::OUT_MIN[23:0];
    end else begin
      world_nxt = shf[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.sat_ld) begin
      world_r <= world_nxt;
    end
  end

  assign world = world_r;

endmodule

// File: hw/rtl/depth_pixel_to_world_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point: depth pixel back-projection to a world point
// Pinhole back-projection with programmed reciprocals, then a 3x4 pose.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one word per depth pixel: column, row, Q4.12 depth
//   and three colour bytes. A pixel with depth below 0.01 m or above 10 m is
//   dropped at the input stage and yields no output word.
//   Output channel (out_*): world x, y, z in signed Q11.12 metres, saturated,
//   with the pixel's colour bytes.
//   Config channel (cfg_*): index selects camera_center, inv_focal or one of
//   the three pose rows; unknown indexes are ignored. cfg_ready is always high.
//   Write configuration only while the pipeline is empty.
//   Throughput: one word per clock unless out_ready stalls. Seven stages:
//   offset, depth product, focal product, rounding, pose product, sum, saturate.
//   Each stage has its own valid bit and loads when it is empty or the stage
//   after it moves on, so bubbles close up and a stall on out_ready holds
//   every full stage in place without loss or repeat.
//   Reset (rst_n low, synchronous): clear all stage valid bits, return the
//   camera registers to zero and the pose to identity.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  // pixel input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [11:0]         in_column,
  input  logic [11:0]         in_row_index,
  input  logic [15:0]         in_depth_raw,
  input  logic [7:0]          in_blue_in,
  input  logic [7:0]          in_green_in,
  input  logic [7:0]          in_red_in,
  // world point output
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [23:0]  out_world_x,
  output logic signed [23:0]  out_world_y,
  output logic signed [23:0]  out_world_z,
  output logic [7:0]          out_blue_out,
  output logic [7:0]          out_green_out,
  output logic [7:0]          out_red_out
);

  localparam int NSTG = 7;

  // configuration registers
  logic [31:0] cam_ctr_r;
  logic [47:0] inv_foc_r;
  logic [63:0] pose_x_r;
  logic [63:0] pose_y_r;
  logic [63:0] pose_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_ctr_r <= '0;
      inv_foc_r <= '0;
      pose_x_r  <= dpw_pkg::POSE_X_RST;
      pose_y_r  <= dpw_pkg::POSE_Y_RST;
      pose_z_r  <= dpw_pkg::POSE_Z_RST;
    end else if (cfg_valid) begin
      unique case (dpw_pkg::cfg_idx_t'(cfg_index))
        dpw_pkg::CFG_CAMERA_CENTER: cam_ctr_r <= cfg_data[31:0];
        dpw_pkg::CFG_INV_FOCAL:     inv_foc_r <= cfg_data[47:0];
        dpw_pkg::CFG_POSE_ROW_X:    pose_x_r  <= cfg_data;
        dpw_pkg::CFG_POSE_ROW_Y:    pose_y_r  <= cfg_data;
        dpw_pkg::CFG_POSE_ROW_Z:    pose_z_r  <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // stage valid bits and the load chain
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] ld;
  logic            pix_ok;

  always_comb begin
    ld[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_ready = ld[0];

  // keep pixels inside the depth window and the image
  assign pix_ok = (in_depth_raw >= dpw_pkg::DEPTH_MIN_RAW)
               && (in_depth_raw <= dpw_pkg::DEPTH_MAX_RAW)
               && (32'(in_column) < dpw_pkg::MAX_COLUMNS)
               && (32'(in_row_index) < dpw_pkg::MAX_ROWS);

  always_comb begin
    vld_nxt = vld_r;
    if (ld[0]) begin
      vld_nxt[0] = in_valid && pix_ok;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // colour rides along every stage
  dpw_pkg::color_t clr_r [NSTG];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      clr_r[0] <= '{blue: in_blue_in, green: in_green_in, red: in_red_in};
    end
    for (int k = 1; k < NSTG; k++) begin
      if (ld[k]) begin
        clr_r[k] <= clr_r[k-1];
      end
    end
  end

  // stage 1: offset from the principal point, Q.4 pixels
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic [15:0]        d1_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      dx_r <= $signed({1'b0, in_column, 4'h0})    - $signed({1'b0, cam_ctr_r[15:0]});
      dy_r <= $signed({1'b0, in_row_index, 4'h0}) - $signed({1'b0, cam_ctr_r[31:16]});
      d1_r <= in_depth_raw;
    end
  end

  // stage 2: times depth, Q.16
  logic signed [33:0] px_r;
  logic signed [33:0] py_r;
  logic [15:0]        d2_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      px_r <= dx_r * $signed({1'b0, d1_r});
      py_r <= dy_r * $signed({1'b0, d1_r});
      d2_r <= d1_r;
    end
  end

  // stage 3: times reciprocal focal length, Q.40
  logic signed [58:0] qx_r;
  logic signed [58:0] qy_r;
  logic [15:0]        d3_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      qx_r <= px_r * $signed({1'b0, inv_foc_r[23:0]});
      qy_r <= py_r * $signed({1'b0, inv_foc_r[47:24]});
      d3_r <= d2_r;
    end
  end

  // stage 4: round half up to Q.12 camera coordinates
  logic signed [58:0] qx_rnd;
  logic signed [58:0] qy_rnd;
  logic signed [28:0] cx_r;
  logic signed [28:0] cy_r;
  logic [15:0]        cz_r;

  assign qx_rnd = qx_r + 59'sd134217728;
  assign qy_rnd = qy_r + 59'sd134217728;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      cx_r <= qx_rnd[56:28];
      cy_r <= qy_rnd[56:28];
      cz_r <= d3_r;
    end
  end

  // stages 5 to 7: pose transform, one unit per world axis
  dpw_pkg::row_en_t row_en;

  assign row_en = '{mul_ld: ld[4], sum_ld: ld[5], sat_ld: ld[6]};

  dpw_world_row u_row_x (
    .clk      (clk),
    .en       (row_en),
    .pose_row (pose_x_r),
    .cam_x    (cx_r),
    .cam_y    (cy_r),
    .cam_z    (cz_r),
    .world    (out_world_x)
  );

  dpw_world_row u_row_y (
    .clk      (clk),
    .en       (row_en),
    .pose_row (pose_y_r),
    .cam_x    (cx_r),
    .cam_y    (cy_r),
    .cam_z    (cz_r),
    .world    (out_world_y)
  );

  dpw_world_row u_row_z (
    .clk      (clk),
    .en       (row_en),
    .pose_row (pose_z_r),
    .cam_x    (cx_r),
    .cam_y    (cy_r),
    .cam_z    (cz_r),
    .world    (out_world_z)
  );

  assign out_valid     = vld_r[NSTG-1];
  assign out_blue_out  = clr_r[NSTG-1].blue;
  assign out_green_out = clr_r[NSTG-1].green;
  assign out_red_out   = clr_r[NSTG-1].red;

endmodule

// File: hw/rtl/dpw_checker.sv
// ----------------------------------------------------------------------------
// dpw_checker: port-level checks of the point pipeline
// Watches reset, fill latency, stall hold and back pressure.
// ----------------------------------------------------------------------------
module dpw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [15:0]        in_depth_raw,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_world_x,
  input logic signed [23:0] out_world_y,
  input logic signed [23:0] out_world_z
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // an empty output stage never pushes back on the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a fresh output word comes from an accepted in-window pixel at the input
  a_fill_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 7)
      && ($past(in_depth_raw, 7) >= 16'd41) && ($past(in_depth_raw, 7) <= 16'd40960))
    else $error("output word without a matching input");

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_world_x)
      && $stable(out_world_y) && $stable(out_world_z))
    else $error("stalled output word changed");

endmodule

bind depth_pixel_to_world_point dpw_checker u_dpw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_depth_raw (in_depth_raw),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_world_x  (out_world_x),
  .out_world_y  (out_world_y),
  .out_world_z  (out_world_z)
);
